/* hw/rtl/ist_pkg.sv */
// ----------------------------------------------------------------------------
// ist_pkg: shared types and constants of the interval set table
// Field widths, request and status codes, and the controller/datapath links.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int VAL_W             = 63;
  localparam int IDX_W             = 6;
  localparam int CNT_W             = 7;
  localparam int TYPE_W            = 3;
  localparam int MAX_INTERVALS_DEF = 64;

  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [TYPE_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_FIND       = 3'd1,
    OP_DELETE     = 3'd2,
    OP_SUBTRACT   = 3'd3,
    OP_COVERS     = 3'd4,
    OP_FIRST_END  = 3'd5,
    OP_LAST_BEGIN = 3'd6,
    OP_READ       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISS      = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_code_t;

  typedef struct packed {
    val_t b;
    val_t e;
  } span_t;

  typedef struct packed {
    logic load;
    logic step;
    logic step2;
    logic finish;
    logic commit;
  } ist_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic need2;
    logic out_free;
  } ist_stat_t;

endpackage

/* hw/rtl/ist_req_if.sv */
// ----------------------------------------------------------------------------
// ist_req_if: request channel
// Valid/ready channel carrying one table request per transfer.
// ----------------------------------------------------------------------------
interface ist_req_if import ist_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  val_t              range_low;
  val_t              range_high;
  logic [IDX_W-1:0]  entry_select;

  modport source (output valid, req_type, range_low, range_high, entry_select,
                  input ready);
  modport sink (input valid, req_type, range_low, range_high, entry_select,
                output ready);
endinterface

/* hw/rtl/ist_rsp_if.sv */
// ----------------------------------------------------------------------------
// ist_rsp_if: response channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface ist_rsp_if import ist_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [IDX_W-1:0] entry_index;
  val_t             entry_begin;
  val_t             entry_end;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, status, entry_index, entry_begin, entry_end, entry_count,
                  input ready);
  modport sink (input valid, status, entry_index, entry_begin, entry_end, entry_count,
                output ready);
endinterface

/* hw/rtl/ist_ctrl.sv */
// ----------------------------------------------------------------------------
// ist_ctrl: sequencer of the interval set table
// Steps the datapath through one scan of the table per request.
// ----------------------------------------------------------------------------
module ist_ctrl import ist_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  ist_stat_t stat,
  output ist_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_PROC  = 6'b000100,
    S_PROC2 = 6'b001000,
    S_FIN   = 6'b010000,
    S_CMT   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      // The entry at the scan index is read here; its data is ready next cycle.
      S_SCAN: begin
        state_next = stat.scan_done ? S_FIN : S_PROC;
      end
      S_PROC: begin
        cmd.step   = 1'b1;
        state_next = stat.need2 ? S_PROC2 : S_SCAN;
      end
      S_PROC2: begin
        cmd.step2  = 1'b1;
        state_next = S_SCAN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_CMT;
      end
      S_CMT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/ist_datapath.sv */
// ----------------------------------------------------------------------------
// ist_datapath: table storage and per-entry logic
// Two banks of intervals; a modifying request rebuilds the table into the
// idle bank and swaps banks when it succeeds.
// ----------------------------------------------------------------------------
module ist_datapath import ist_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ist_cmd_t          cmd,
  output ist_stat_t         stat,
  input  logic [TYPE_W-1:0] req_type,
  input  val_t              range_low,
  input  val_t              range_high,
  input  logic [IDX_W-1:0]  entry_select,
  input  logic              rsp_ready,
  output logic              rsp_valid,
  output logic [1:0]        status,
  output logic [IDX_W-1:0]  entry_index,
  output val_t              entry_begin,
  output val_t              entry_end,
  output logic [CNT_W-1:0]  entry_count
);

  localparam int AW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam logic [CW-1:0] MAX_N = CW'(MAX_INTERVALS);

  span_t mem [0:(2**(AW+1))-1];
  span_t rdata;

  op_t              op;
  val_t             lo, hi;
  logic [IDX_W-1:0] sel;
  logic             hold, bank, full, hit, merging;
  logic [CW-1:0]    count, ridx, n, res_idx;
  span_t            acc, res;

  logic             w1_en, w2_en, cap, merge, place;
  span_t            w1, w2, fin_span;
  logic             wen, ins_cap;
  span_t            wdata;
  logic             modify, do_commit;

  logic [VAL_W:0]   lo_x, hi_p1, re_p1;
  logic             below, touch, in_pt;

  logic [1:0]       status_next;
  logic [IDX_W-1:0] entry_index_next;
  val_t             entry_begin_next, entry_end_next;

  always_ff @(posedge clk) begin
    rdata <= mem[{bank, ridx[AW-1:0]}];
  end

  always_comb begin
    lo_x  = {1'b0, lo};
    hi_p1 = {1'b0, hi} + (VAL_W+1)'(1);
    re_p1 = {1'b0, rdata.e} + (VAL_W+1)'(1);
    below = re_p1 < lo_x;
    touch = {1'b0, rdata.b} <= hi_p1;
    in_pt = (rdata.b <= lo) && (lo <= rdata.e);
  end

  // Decisions for the entry that has just been read.
  always_comb begin
    w1_en = 1'b0;
    w2_en = 1'b0;
    w1    = rdata;
    w2    = rdata;
    cap   = 1'b0;
    merge = 1'b0;
    place = 1'b0;
    case (op)
      OP_INSERT: begin
        if (hit || below) begin
          w1_en = 1'b1;
        end else if (touch) begin
          merge = 1'b1;
        end else begin
          w1_en = 1'b1;
          w1    = merging ? acc : span_t'{b: lo, e: hi};
          place = 1'b1;
          w2_en = 1'b1;
        end
      end
      OP_DELETE: begin
        if (!hit && in_pt) begin
          cap = 1'b1;
        end else begin
          w1_en = 1'b1;
        end
      end
      OP_SUBTRACT: begin
        if (!hold) begin
          w1_en = 1'b1;
          if (!(rdata.e < lo || rdata.b > hi)) begin
            if (rdata.b < lo) begin
              w1.e  = lo - VAL_W'(1);
              w2_en = rdata.e > hi;
              w2.b  = hi + VAL_W'(1);
            end else if (rdata.e > hi) begin
              w1.b = hi + VAL_W'(1);
            end else begin
              w1_en = 1'b0;
            end
          end
        end
      end
      OP_FIND, OP_COVERS: cap = !hit && in_pt;
      OP_FIRST_END:       cap = !hit && (rdata.e >= lo);
      OP_LAST_BEGIN:      cap = rdata.b <= lo;
      OP_READ:            cap = !hit && (32'(ridx) == 32'(sel));
      default:            cap = 1'b0;
    endcase
  end

  // The second write only happens when the first step asked for it, so it is
  // always taken; the entry is still in rdata.
  always_comb begin
    fin_span = merging ? acc : span_t'{b: lo, e: hi};
    wen      = 1'b0;
    wdata    = w1;
    ins_cap  = 1'b0;
    if (cmd.step) begin
      wen     = w1_en;
      ins_cap = place;
    end else if (cmd.step2) begin
      wen   = 1'b1;
      wdata = w2;
    end else if (cmd.finish && op == OP_INSERT && !hit) begin
      wen     = 1'b1;
      wdata   = fin_span;
      ins_cap = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wen && n != MAX_N) begin
      mem[{~bank, n[AW-1:0]}] <= wdata;
    end
  end

  assign modify    = (op == OP_INSERT) || (op == OP_DELETE) || (op == OP_SUBTRACT);
  assign do_commit = modify && !full && !hold;

  always_comb begin
    stat.scan_done = ridx == count;
    stat.need2     = w2_en;
    stat.out_free  = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      bank      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
        if (do_commit) begin
          bank  <= ~bank;
          count <= n;
        end
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result fields for the request that is about to commit.
  always_comb begin
    status_next      = ST_OK;
    entry_index_next = '0;
    entry_begin_next = '0;
    entry_end_next   = '0;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          entry_index_next = IDX_W'(res_idx);
          entry_begin_next = res.b;
          entry_end_next   = res.e;
        end
      end
      OP_SUBTRACT: begin
        if (full) status_next = ST_FULL;
      end
      OP_COVERS: begin
        if (hit && !(lo > hi) && res.e >= hi) begin
          entry_index_next = IDX_W'(res_idx);
          entry_begin_next = res.b;
          entry_end_next   = res.e;
        end else begin
          status_next = ST_MISS;
        end
      end
      OP_READ: begin
        if (hit) begin
          entry_index_next = IDX_W'(res_idx);
          entry_begin_next = res.b;
          entry_end_next   = res.e;
        end else begin
          status_next      = ST_BAD_INDEX;
          entry_index_next = sel;
        end
      end
      default: begin
        if (hit) begin
          entry_index_next = IDX_W'(res_idx);
          entry_begin_next = res.b;
          entry_end_next   = res.e;
        end else begin
          status_next = ST_MISS;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= op_t'(req_type);
      sel     <= entry_select;
      hold    <= (op_t'(req_type) == OP_SUBTRACT) && (range_low > range_high);
      ridx    <= '0;
      n       <= '0;
      full    <= 1'b0;
      hit     <= 1'b0;
      merging <= 1'b0;
      if (op_t'(req_type) == OP_INSERT && range_low > range_high) begin
        lo <= range_high;
        hi <= range_low;
      end else begin
        lo <= range_low;
        hi <= range_high;
      end
    end
    if (wen) begin
      if (n == MAX_N) begin
        full <= 1'b1;
      end else begin
        n <= n + CW'(1);
      end
    end
    if (cmd.step) begin
      ridx <= ridx + CW'(1);
      if (cap) begin
        hit     <= 1'b1;
        res     <= rdata;
        res_idx <= ridx;
      end
      if (merge) begin
        merging <= 1'b1;
        if (!merging) begin
          acc.b <= (rdata.b < lo) ? rdata.b : lo;
          acc.e <= (rdata.e > hi) ? rdata.e : hi;
        end else if (rdata.e > acc.e) begin
          acc.e <= rdata.e;
        end
      end
    end
    if (ins_cap) begin
      hit     <= 1'b1;
      res     <= wdata;
      res_idx <= n;
    end
    if (cmd.commit) begin
      status      <= status_next;
      entry_index <= entry_index_next;
      entry_begin <= entry_begin_next;
      entry_end   <= entry_end_next;
      entry_count <= CNT_W'(do_commit ? n : count);
    end
  end

endmodule

/* hw/rtl/interval_set_table_core.sv */
// ----------------------------------------------------------------------------
// interval_set_table_core: sorted table of disjoint closed intervals
// Top level joining the request sequencer and the table datapath.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel and each produces exactly one result on
// the rsp channel; a transfer happens when valid and ready are both high.
// The block works on one request at a time. Every request walks the whole
// table once in order: each entry is read from the bank memory, then decided
// on from its data, and an entry that a subtract splits in two, or that an
// insert places a new interval in front of, also takes a second write. The
// scan loop runs over the single read port of the bank memory, and the block
// is ready for the next request as soon as the result is registered.
// Requests that change the table write the new contents into the idle bank
// and swap banks at the end, so a request that finds the table full leaves
// it as it was. Results wait in an output register; a stalled receiver only
// holds the next request at its final step, while a new request may be
// accepted and scanned as soon as the previous result is registered.
// Reset clears the interval count and the response valid; the interval
// storage itself needs no clearing since only entries below the count are
// ever used.
// ----------------------------------------------------------------------------
module interval_set_table_core import ist_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input logic        clk,
  input logic        rst,
  ist_req_if.sink    req,
  ist_rsp_if.source  rsp
);

  // Command and status link between the sequencer and the datapath.
  ist_cmd_t  cmd;
  ist_stat_t stat;

  ist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ist_datapath #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req.req_type),
    .range_low    (req.range_low),
    .range_high   (req.range_high),
    .entry_select (req.entry_select),
    .rsp_ready    (rsp.ready),
    .rsp_valid    (rsp.valid),
    .status       (rsp.status),
    .entry_index  (rsp.entry_index),
    .entry_begin  (rsp.entry_begin),
    .entry_end    (rsp.entry_end),
    .entry_count  (rsp.entry_count)
  );

endmodule

/* hw/rtl/ist_chk.sv */
// ----------------------------------------------------------------------------
// ist_chk: port checks for the interval set table
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module ist_chk import ist_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [1:0]       status,
  input logic [IDX_W-1:0] entry_index,
  input val_t             entry_begin,
  input val_t             entry_end,
  input logic [CNT_W-1:0] entry_count
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(status) && $stable(entry_index) &&
      $stable(entry_begin) && $stable(entry_end) && $stable(entry_count))
    else $error("response payload changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in progress");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL || status == ST_BAD_INDEX) |->
      entry_begin == '0 && entry_end == '0)
    else $error("failed request reports nonzero bounds");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind interval_set_table_core ist_chk u_ist_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .entry_index (rsp.entry_index),
  .entry_begin (rsp.entry_begin),
  .entry_end   (rsp.entry_end),
  .entry_count (rsp.entry_count)
);

/* sim/interval_set_table_core_tb.sv */
// ----------------------------------------------------------------------------
// interval_set_table_core_tb: self-checking regression of the interval table
// Drives table requests over the valid/ready request channel, predicts every
// result with a behavioral copy of the interval table and checks each result
// transfer field by field under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module interval_set_table_core_tb;
  import ist_pkg::*;

  localparam int   TABLE_DEPTH = MAX_INTERVALS_DEF;
  localparam val_t VAL_MAX     = {VAL_W{1'b1}};
  // The limit allows every one of roughly 650 requests a full-table scan with
  // a long sender gap and a long receiver stall on top.
  localparam int   CYCLE_LIMIT = 1500000;
  localparam int   TAIL_CYCLES = 200;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] index;
    val_t             b;
    val_t             e;
    logic [CNT_W-1:0] count;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ist_req_if req_ch ();
  ist_rsp_if rsp_ch ();

  interval_set_table_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Behavioral copy of the table, kept in step with every accepted transfer.
  val_t          span_begins [TABLE_DEPTH];
  val_t          span_ends   [TABLE_DEPTH];
  int            span_count;
  table_result_t pending_results[$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int cycles = 0;

  function automatic table_result_t make_result(status_code_t st, int idx, val_t b, val_t e);
    table_result_t r;
    r.status = st;
    r.index  = idx[IDX_W-1:0];
    r.b      = b;
    r.e      = e;
    r.count  = span_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic int find_holding(val_t p);
    for (int i = 0; i < span_count; i++)
      if (span_begins[i] <= p && p <= span_ends[i]) return i;
    return span_count;
  endfunction

  function automatic void drop_spans(int first, int n);
    for (int k = first; k + n < span_count; k++) begin
      span_begins[k] = span_begins[k+n];
      span_ends[k]   = span_ends[k+n];
    end
    span_count -= n;
  endfunction

  // Applies one request to the table copy and returns the result it causes.
  function automatic table_result_t apply_request(op_t op, val_t lo, val_t hi,
                                                  logic [IDX_W-1:0] sel);
    int          i, j, n;
    logic [63:0] lo64, hi64;
    val_t        t, nb, ne, b, e;
    val_t        new_b [TABLE_DEPTH];
    val_t        new_e [TABLE_DEPTH];
    case (op)
      OP_INSERT: begin
        if (lo > hi) begin
          t = lo; lo = hi; hi = t;
        end
        lo64 = {1'b0, lo};
        hi64 = {1'b0, hi};
        i = 0;
        while (i < span_count && {1'b0, span_ends[i]} + 64'd1 < lo64) i++;
        j = i;
        while (j < span_count && {1'b0, span_begins[j]} <= hi64 + 64'd1) j++;
        if (j == i) begin
          if (span_count >= TABLE_DEPTH) return make_result(ST_FULL, 0, '0, '0);
          for (int k = span_count; k > i; k--) begin
            span_begins[k] = span_begins[k-1];
            span_ends[k]   = span_ends[k-1];
          end
          span_begins[i] = lo;
          span_ends[i]   = hi;
          span_count++;
          return make_result(ST_OK, i, lo, hi);
        end
        nb = span_begins[i] < lo ? span_begins[i] : lo;
        ne = span_ends[j-1] > hi ? span_ends[j-1] : hi;
        span_begins[i] = nb;
        span_ends[i]   = ne;
        drop_spans(i + 1, j - i - 1);
        return make_result(ST_OK, i, nb, ne);
      end
      OP_FIND: begin
        i = find_holding(lo);
        if (i >= span_count) return make_result(ST_MISS, 0, '0, '0);
        return make_result(ST_OK, i, span_begins[i], span_ends[i]);
      end
      OP_DELETE: begin
        i = find_holding(lo);
        if (i >= span_count) return make_result(ST_MISS, 0, '0, '0);
        b = span_begins[i];
        e = span_ends[i];
        drop_spans(i, 1);
        return make_result(ST_OK, i, b, e);
      end
      OP_SUBTRACT: begin
        if (lo > hi) return make_result(ST_OK, 0, '0, '0);
        n = 0;
        for (i = 0; i < span_count; i++) begin
          b = span_begins[i];
          e = span_ends[i];
          if (e < lo || b > hi) begin
            if (n >= TABLE_DEPTH) return make_result(ST_FULL, 0, '0, '0);
            new_b[n] = b; new_e[n] = e; n++;
          end else begin
            if (b < lo) begin
              if (n >= TABLE_DEPTH) return make_result(ST_FULL, 0, '0, '0);
              new_b[n] = b; new_e[n] = lo - 1'b1; n++;
            end
            if (e > hi) begin
              if (n >= TABLE_DEPTH) return make_result(ST_FULL, 0, '0, '0);
              new_b[n] = hi + 1'b1; new_e[n] = e; n++;
            end
          end
        end
        for (i = 0; i < n; i++) begin
          span_begins[i] = new_b[i];
          span_ends[i]   = new_e[i];
        end
        span_count = n;
        return make_result(ST_OK, 0, '0, '0);
      end
      OP_COVERS: begin
        if (lo > hi) return make_result(ST_MISS, 0, '0, '0);
        i = find_holding(lo);
        if (i >= span_count || span_ends[i] < hi) return make_result(ST_MISS, 0, '0, '0);
        return make_result(ST_OK, i, span_begins[i], span_ends[i]);
      end
      OP_FIRST_END: begin
        for (i = 0; i < span_count; i++)
          if (span_ends[i] >= lo) return make_result(ST_OK, i, span_begins[i], span_ends[i]);
        return make_result(ST_MISS, 0, '0, '0);
      end
      OP_LAST_BEGIN: begin
        for (i = span_count; i > 0; i--)
          if (span_begins[i-1] <= lo)
            return make_result(ST_OK, i - 1, span_begins[i-1], span_ends[i-1]);
        return make_result(ST_MISS, 0, '0, '0);
      end
      default: begin
        if (sel >= span_count) return make_result(ST_BAD_INDEX, sel, '0, '0);
        return make_result(ST_OK, sel, span_begins[sel], span_ends[sel]);
      end
    endcase
  endfunction

  // Sends one request. Inputs change only at the falling edge; valid is left
  // high after the transfer so that back-to-back requests need no gap.
  task automatic send_request(op_t op, val_t lo, val_t hi, logic [IDX_W-1:0] sel);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid        = 1'b1;
    req_ch.req_type     = op;
    req_ch.range_low    = lo;
    req_ch.range_high   = hi;
    req_ch.entry_select = sel;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(apply_request(op, lo, hi, sel));
    requests_sent++;
  endtask

  // Holds the sender back until every outstanding result has been seen.
  task automatic wait_for_results();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // The receiver stalls at random; the pattern changes from phase to phase.
  always @(negedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Every result transfer is checked against the oldest pending expectation.
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer, status %0d", rsp_ch.status);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.entry_index !== want.index ||
            rsp_ch.entry_begin !== want.b || rsp_ch.entry_end !== want.e ||
            rsp_ch.entry_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st=%0d idx=%0d b=%0h e=%0h cnt=%0d, got st=%0d idx=%0d b=%0h e=%0h cnt=%0d",
                     want.status, want.index, want.b, want.e, want.count,
                     rsp_ch.status, rsp_ch.entry_index, rsp_ch.entry_begin,
                     rsp_ch.entry_end, rsp_ch.entry_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Extremes, both adjacency directions, merges and every kind of miss.
  task automatic test_directed();
    send_request(OP_READ, '0, '0, 6'd0);
    send_request(OP_FIND, 63'd5, '0, '0);
    send_request(OP_INSERT, 63'd0, 63'd0, '0);
    send_request(OP_INSERT, VAL_MAX, VAL_MAX, '0);
    send_request(OP_INSERT, 63'd30, 63'd20, '0);
    send_request(OP_INSERT, 63'd31, 63'd35, '0);
    send_request(OP_INSERT, 63'd10, 63'd19, '0);
    send_request(OP_INSERT, 63'd1, 63'd2, '0);
    send_request(OP_INSERT, 63'd50, 63'd60, '0);
    send_request(OP_INSERT, 63'd40, 63'd70, '0);
    send_request(OP_COVERS, 63'd12, 63'd33, '0);
    send_request(OP_COVERS, 63'd12, 63'd45, '0);
    send_request(OP_COVERS, 63'd33, 63'd12, '0);
    send_request(OP_FIRST_END, 63'd36, '0, '0);
    send_request(OP_LAST_BEGIN, 63'd39, '0, '0);
    send_request(OP_FIRST_END, VAL_MAX, '0, '0);
    send_request(OP_LAST_BEGIN, '0, '0, '0);
    send_request(OP_SUBTRACT, 63'd15, 63'd25, '0);
    send_request(OP_SUBTRACT, 63'd60, 63'd50, '0);
    send_request(OP_SUBTRACT, 63'd65, VAL_MAX, '0);
    send_request(OP_DELETE, 63'd45, '0, '0);
    send_request(OP_DELETE, 63'd45, '0, '0);
    send_request(OP_READ, '0, '0, 6'd1);
    send_request(OP_READ, '0, '0, 6'd63);
    send_request(OP_SUBTRACT, '0, VAL_MAX, '0);
  endtask

  // Fills the table, then asks for one more entry by insert and by split.
  task automatic test_full_table();
    for (int k = 0; k < TABLE_DEPTH; k++)
      send_request(OP_INSERT, 63'(4 * k), 63'(4 * k + 2), '0);
    send_request(OP_INSERT, 63'd1000, 63'd1001, '0);
    send_request(OP_SUBTRACT, 63'd21, 63'd21, '0);
    send_request(OP_READ, '0, '0, 6'd63);
    send_request(OP_INSERT, 63'd3, 63'd3, '0);
    send_request(OP_SUBTRACT, 63'd0, 63'd3, '0);
    send_request(OP_SUBTRACT, '0, VAL_MAX, '0);
  endtask

  function automatic val_t pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 63'($urandom_range(400));
    if (r < 90) return VAL_MAX - 63'($urandom_range(40));
    return 63'({$urandom, $urandom});
  endfunction

  // Mostly inserts and lookups in a narrow window, so the table grows, merges
  // and fills; occasional wide values and clearing subtracts add noise.
  task automatic test_random(int items);
    int   r;
    val_t lo, hi;
    op_t  op;
    for (int n = 0; n < items; n++) begin
      r  = $urandom_range(99);
      lo = pick_value();
      hi = ($urandom_range(3) == 0) ? pick_value() : lo + 63'($urandom_range(12));
      if (r < 35) op = OP_INSERT;
      else if (r < 97) op = op_t'($urandom_range(7));
      else begin
        op = OP_SUBTRACT;
        lo = '0;
        hi = VAL_MAX;
      end
      send_request(op, lo, hi, 6'($urandom));
    end
  endtask

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.req_type     = '0;
    req_ch.range_low    = '0;
    req_ch.range_high   = '0;
    req_ch.entry_select = '0;
    span_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_full_table();
    wait_for_results();

    sender_idle_pct = 0;  receiver_stall_pct = 0;
    test_random(150);
    sender_idle_pct = 86; receiver_stall_pct = 0;
    test_random(135);
    wait_for_results();
    sender_idle_pct = 0;  receiver_stall_pct = 86;
    test_random(135);
    sender_idle_pct = 13; receiver_stall_pct = 13;
    test_random(135);

    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d requests and %0d results over four idling patterns",
             requests_sent, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
